// ===== rtl/sbh_pkg.sv =====
// Package for the serial bootloader host engine.
// Holds field widths, protocol bytes, codes and the shared state and result types.
// No dependencies.
package sbh_pkg;

   localparam int BLOCK_SIZE = 256;
   localparam int MAX_LENGTH = 65536;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 17;
   localparam int BLK_W  = $clog2(BLOCK_SIZE + 1);
   localparam int RES_MAX = 5;
   localparam int CNT_W  = $clog2(RES_MAX + 1);
   localparam int IDX_W  = $clog2(RES_MAX);

   localparam logic [7:0] ACK_BYTE  = 8'h79;
   localparam logic [7:0] NACK_BYTE = 8'h1F;
   localparam logic [7:0] SYNC_BYTE = 8'h7F;
   localparam logic [7:0] CMD_WRITE = 8'h31;
   localparam logic [7:0] CMD_READ  = 8'h11;
   localparam logic [7:0] CMD_ERASE = 8'h43;
   localparam logic [7:0] ERASE_ALL = 8'hFF;

   // request kinds
   localparam logic [1:0] IK_REQ   = 2'd0;
   localparam logic [1:0] IK_DATA  = 2'd1;
   localparam logic [1:0] IK_REPLY = 2'd2;

   // operations
   localparam logic [1:0] OP_CONNECT = 2'd0;
   localparam logic [1:0] OP_ERASE   = 2'd1;
   localparam logic [1:0] OP_WRITE   = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   // result kinds
   localparam logic [2:0] RK_SEND  = 3'd0;
   localparam logic [2:0] RK_READ  = 3'd1;
   localparam logic [2:0] RK_DONE  = 3'd2;
   localparam logic [2:0] RK_NACK  = 3'd3;
   localparam logic [2:0] RK_BAD   = 3'd4;
   localparam logic [2:0] RK_ORDER = 3'd5;
   localparam logic [2:0] RK_READY = 3'd6;

   // phases
   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_CONN_ACK   = 4'd1;
   localparam logic [3:0] PH_ERASE_ACK1 = 4'd2;
   localparam logic [3:0] PH_ERASE_ACK2 = 4'd3;
   localparam logic [3:0] PH_CMD_ACK    = 4'd4;
   localparam logic [3:0] PH_ADDR_ACK   = 4'd5;
   localparam logic [3:0] PH_WR_DATA    = 4'd6;
   localparam logic [3:0] PH_WR_ACK     = 4'd7;
   localparam logic [3:0] PH_RD_CNT_ACK = 4'd8;
   localparam logic [3:0] PH_RD_DATA    = 4'd9;

   typedef struct packed {
      logic [3:0]        phase;
      logic [1:0]        cur_op;
      logic [ADDR_W-1:0] block_address;
      logic [LEN_W-1:0]  bytes_remaining;
      logic [BLK_W-1:0]  block_bytes_left;
      logic [7:0]        checksum;
      logic              connect_retried;
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        operation;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [7:0]        byte_in;
   } item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
   } res_type;

   typedef struct packed {
      res_type [RES_MAX-1:0] res;
      logic [CNT_W-1:0]      cnt;
   } step_out_type;

endpackage

// ===== rtl/sbh_req_if.sv =====
// Request channel of the serial bootloader host engine: valid/ready plus item fields.
// Depends on sbh_pkg for field widths.
interface sbh_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [1:0]                operation;
   logic [sbh_pkg::ADDR_W-1:0] address;
   logic [sbh_pkg::LEN_W-1:0] length;
   logic [7:0]                byte_in;

   modport source(output valid, kind, operation, address, length, byte_in, input ready);
   modport sink(input valid, kind, operation, address, length, byte_in, output ready);
endinterface

// ===== rtl/sbh_rsp_if.sv =====
// Result channel of the serial bootloader host engine: valid/ready plus result fields.
// No dependencies.
interface sbh_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [7:0] byte_out;
   logic       last;

   modport source(output valid, result_kind, byte_out, last, input ready);
   modport sink(input valid, result_kind, byte_out, last, output ready);
endinterface

// ===== rtl/serial_bootloader_host_engine.sv =====
// Host side of a serial bootloader exchange. A request is captured in an input register,
// one step of the protocol is evaluated against the state, and its zero to five results
// are loaded into a result buffer that drains one result per cycle while the result side
// is ready. A request holds the result side until its results are taken; the next request
// waits in the input register meanwhile and is evaluated in the cycle the last result of
// the previous one is taken.
// Depends on sbh_pkg, sbh_req_if, sbh_rsp_if and sbh_step.
module serial_bootloader_host_engine (
   input logic       clock,
   input logic       reset,
   sbh_req_if.sink   req_ch,
   sbh_rsp_if.source rsp_ch
);

   sbh_pkg::item_type                  item_ff;
   logic                               item_valid_ff;
   sbh_pkg::state_type                 state_ff;
   sbh_pkg::state_type                 state_in;
   sbh_pkg::step_out_type              step_out;
   sbh_pkg::res_type [sbh_pkg::RES_MAX-1:0] res_ff;
   logic [sbh_pkg::CNT_W-1:0]          res_cnt_ff;
   logic [sbh_pkg::IDX_W-1:0]          res_idx_ff;

   logic pop;
   logic last_slot;
   logic buf_free;
   logic process;
   logic load;

   sbh_step u_step (
      .st   (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .out  (step_out)
   );

   assign last_slot = (sbh_pkg::CNT_W'(res_idx_ff) == res_cnt_ff - sbh_pkg::CNT_W'(1));
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign buf_free  = (res_cnt_ff == '0) || (pop && last_slot);
   assign process   = item_valid_ff && buf_free;
   assign load      = req_ch.valid && req_ch.ready;

   assign req_ch.ready       = !item_valid_ff || process;
   assign rsp_ch.valid       = (res_cnt_ff != '0);
   assign rsp_ch.result_kind = res_ff[res_idx_ff].kind;
   assign rsp_ch.byte_out    = res_ff[res_idx_ff].data;
   assign rsp_ch.last        = last_slot;

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= '{req_ch.kind, req_ch.operation, req_ch.address,
                      req_ch.length, req_ch.byte_in};
      end
      if (process) begin
         res_ff <= step_out.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         state_ff      <= '{sbh_pkg::PH_IDLE, 2'd0, '0, '0, '0, 8'd0, 1'b0};
         res_cnt_ff    <= '0;
         res_idx_ff    <= '0;
      end else begin
         if (load) begin
            item_valid_ff <= 1'b1;
         end else if (process) begin
            item_valid_ff <= 1'b0;
         end
         if (process) begin
            state_ff   <= state_in;
            res_cnt_ff <= step_out.cnt;
            res_idx_ff <= '0;
         end else if (pop) begin
            if (last_slot) begin
               res_cnt_ff <= '0;
               res_idx_ff <= '0;
            end else begin
               res_idx_ff <= res_idx_ff + sbh_pkg::IDX_W'(1);
            end
         end
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= sbh_pkg::CNT_W'(sbh_pkg::RES_MAX))
      else $error("result count above maximum");

   a_idx_in_buf: assert property (@(posedge clock) disable iff (reset)
      (res_cnt_ff != '0) |-> (sbh_pkg::CNT_W'(res_idx_ff) < res_cnt_ff))
      else $error("result index beyond filled slots");

   a_process_free: assert property (@(posedge clock) disable iff (reset)
      process |-> ((res_cnt_ff == '0) || (pop && last_slot)))
      else $error("request evaluated while results pending");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (pop && last_slot && !process) |=> !rsp_ch.valid)
      else $error("result buffer not empty after final result");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !process |=> (state_ff == $past(state_ff)))
      else $error("state changed without a request");

endmodule

// ===== rtl/sbh_step.sv =====
// Protocol step logic: next state and the list of results for one request.
// Purely combinational. Depends on sbh_pkg.
module sbh_step (
   input  sbh_pkg::state_type    st,
   input  sbh_pkg::item_type     item,
   output sbh_pkg::state_type    nxt,
   output sbh_pkg::step_out_type out
);

   logic                         ok;
   logic [2:0]                   fail_kind;
   logic [sbh_pkg::BLK_W-1:0]    blk;
   logic [sbh_pkg::BLK_W-1:0]    blk_m1;
   logic [7:0]                   blk_byte;
   logic [sbh_pkg::LEN_W-1:0]    rem_after;
   logic [sbh_pkg::ADDR_W-1:0]   addr_after;
   logic [7:0]                   cmd_cur;
   logic [7:0]                   cmd_req;
   logic [sbh_pkg::LEN_W-1:0]    len_sat;
   logic [sbh_pkg::BLK_W-1:0]    bbl_dec;
   logic [7:0]                   cs_new;
   logic [7:0]                   addr_xor;

   always_comb begin
      ok        = (item.byte_in == sbh_pkg::ACK_BYTE);
      fail_kind = (item.byte_in == sbh_pkg::NACK_BYTE) ? sbh_pkg::RK_NACK : sbh_pkg::RK_BAD;
      blk       = (st.bytes_remaining < sbh_pkg::LEN_W'(sbh_pkg::BLOCK_SIZE))
                  ? sbh_pkg::BLK_W'(st.bytes_remaining)
                  : sbh_pkg::BLK_W'(sbh_pkg::BLOCK_SIZE);
      blk_m1    = blk - sbh_pkg::BLK_W'(1);
      blk_byte  = 8'(blk_m1);
      rem_after  = st.bytes_remaining - sbh_pkg::LEN_W'(blk);
      addr_after = st.block_address + sbh_pkg::ADDR_W'(blk);
      cmd_cur   = (st.cur_op == sbh_pkg::OP_WRITE) ? sbh_pkg::CMD_WRITE : sbh_pkg::CMD_READ;
      cmd_req   = (item.operation == sbh_pkg::OP_WRITE) ? sbh_pkg::CMD_WRITE
                                                         : sbh_pkg::CMD_READ;
      len_sat   = (item.length > sbh_pkg::LEN_W'(sbh_pkg::MAX_LENGTH))
                  ? sbh_pkg::LEN_W'(sbh_pkg::MAX_LENGTH) : item.length;
      bbl_dec   = st.block_bytes_left - sbh_pkg::BLK_W'(1);
      cs_new    = st.checksum ^ item.byte_in;
      addr_xor  = st.block_address[31:24] ^ st.block_address[23:16]
                ^ st.block_address[15:8] ^ st.block_address[7:0];

      nxt = st;
      out = '0;

      case (item.kind)
         sbh_pkg::IK_REQ: begin
            if (st.phase == sbh_pkg::PH_IDLE) begin
               nxt.cur_op           = item.operation;
               nxt.connect_retried  = 1'b0;
               nxt.checksum         = 8'd0;
               nxt.block_bytes_left = '0;
               case (item.operation)
                  sbh_pkg::OP_CONNECT: begin
                     out.res[0] = '{sbh_pkg::RK_SEND, sbh_pkg::SYNC_BYTE};
                     out.cnt    = 3'd1;
                     nxt.phase  = sbh_pkg::PH_CONN_ACK;
                  end
                  sbh_pkg::OP_ERASE: begin
                     out.res[0] = '{sbh_pkg::RK_SEND, sbh_pkg::CMD_ERASE};
                     out.res[1] = '{sbh_pkg::RK_SEND, ~sbh_pkg::CMD_ERASE};
                     out.cnt    = 3'd2;
                     nxt.phase  = sbh_pkg::PH_ERASE_ACK1;
                  end
                  default: begin
                     nxt.block_address   = item.address;
                     nxt.bytes_remaining = len_sat;
                     if (len_sat == '0) begin
                        out.res[0] = '{sbh_pkg::RK_DONE, 8'd0};
                        out.cnt    = 3'd1;
                        nxt.phase  = sbh_pkg::PH_IDLE;
                     end else begin
                        out.res[0] = '{sbh_pkg::RK_SEND, cmd_req};
                        out.res[1] = '{sbh_pkg::RK_SEND, ~cmd_req};
                        out.cnt    = 3'd2;
                        nxt.phase  = sbh_pkg::PH_CMD_ACK;
                     end
                  end
               endcase
            end else begin
               out.res[0] = '{sbh_pkg::RK_ORDER, 8'd0};
               out.cnt    = 3'd1;
            end
         end

         sbh_pkg::IK_DATA: begin
            if (st.phase == sbh_pkg::PH_WR_DATA && st.block_bytes_left != '0) begin
               out.res[0]           = '{sbh_pkg::RK_SEND, item.byte_in};
               out.cnt              = 3'd1;
               nxt.checksum         = cs_new;
               nxt.block_bytes_left = bbl_dec;
               if (bbl_dec == '0) begin
                  out.res[1] = '{sbh_pkg::RK_SEND, cs_new};
                  out.cnt    = 3'd2;
                  nxt.phase  = sbh_pkg::PH_WR_ACK;
               end
            end else begin
               out.res[0] = '{sbh_pkg::RK_ORDER, 8'd0};
               out.cnt    = 3'd1;
            end
         end

         sbh_pkg::IK_REPLY: begin
            if (!ok && st.phase != sbh_pkg::PH_RD_DATA && st.phase != sbh_pkg::PH_IDLE
                && st.phase != sbh_pkg::PH_WR_DATA
                && !(st.phase == sbh_pkg::PH_CONN_ACK && !st.connect_retried)) begin
               out.res[0] = '{fail_kind, item.byte_in};
               out.cnt    = 3'd1;
               nxt.phase  = sbh_pkg::PH_IDLE;
            end else begin
               case (st.phase)
                  sbh_pkg::PH_CONN_ACK: begin
                     if (ok) begin
                        out.res[0] = '{sbh_pkg::RK_DONE, 8'd0};
                        nxt.phase  = sbh_pkg::PH_IDLE;
                     end else begin
                        out.res[0]          = '{sbh_pkg::RK_SEND, sbh_pkg::SYNC_BYTE};
                        nxt.connect_retried = 1'b1;
                     end
                     out.cnt = 3'd1;
                  end
                  sbh_pkg::PH_ERASE_ACK1: begin
                     out.res[0] = '{sbh_pkg::RK_SEND, sbh_pkg::ERASE_ALL};
                     out.res[1] = '{sbh_pkg::RK_SEND, ~sbh_pkg::ERASE_ALL};
                     out.cnt    = 3'd2;
                     nxt.phase  = sbh_pkg::PH_ERASE_ACK2;
                  end
                  sbh_pkg::PH_ERASE_ACK2: begin
                     out.res[0] = '{sbh_pkg::RK_DONE, 8'd0};
                     out.cnt    = 3'd1;
                     nxt.phase  = sbh_pkg::PH_IDLE;
                  end
                  sbh_pkg::PH_CMD_ACK: begin
                     out.res[0] = '{sbh_pkg::RK_SEND, st.block_address[31:24]};
                     out.res[1] = '{sbh_pkg::RK_SEND, st.block_address[23:16]};
                     out.res[2] = '{sbh_pkg::RK_SEND, st.block_address[15:8]};
                     out.res[3] = '{sbh_pkg::RK_SEND, st.block_address[7:0]};
                     out.res[4] = '{sbh_pkg::RK_SEND, addr_xor};
                     out.cnt    = 3'd5;
                     nxt.phase  = sbh_pkg::PH_ADDR_ACK;
                  end
                  sbh_pkg::PH_ADDR_ACK: begin
                     nxt.block_bytes_left = blk;
                     out.res[0] = '{sbh_pkg::RK_SEND, blk_byte};
                     out.cnt    = 3'd2;
                     if (st.cur_op == sbh_pkg::OP_WRITE) begin
                        nxt.checksum = blk_byte;
                        out.res[1]   = '{sbh_pkg::RK_READY, 8'd0};
                        nxt.phase    = sbh_pkg::PH_WR_DATA;
                     end else begin
                        out.res[1] = '{sbh_pkg::RK_SEND, ~blk_byte};
                        nxt.phase  = sbh_pkg::PH_RD_CNT_ACK;
                     end
                  end
                  sbh_pkg::PH_WR_ACK: begin
                     nxt.bytes_remaining = rem_after;
                     nxt.block_address   = addr_after;
                     if (rem_after == '0) begin
                        out.res[0] = '{sbh_pkg::RK_DONE, 8'd0};
                        out.cnt    = 3'd1;
                        nxt.phase  = sbh_pkg::PH_IDLE;
                     end else begin
                        out.res[0] = '{sbh_pkg::RK_SEND, cmd_cur};
                        out.res[1] = '{sbh_pkg::RK_SEND, ~cmd_cur};
                        out.cnt    = 3'd2;
                        nxt.phase  = sbh_pkg::PH_CMD_ACK;
                     end
                  end
                  sbh_pkg::PH_RD_CNT_ACK: begin
                     nxt.phase = sbh_pkg::PH_RD_DATA;
                  end
                  sbh_pkg::PH_RD_DATA: begin
                     out.res[0] = '{sbh_pkg::RK_READ, item.byte_in};
                     out.cnt    = 3'd1;
                     if (st.block_bytes_left != '0) begin
                        nxt.block_bytes_left = bbl_dec;
                     end
                     if (st.block_bytes_left == '0 || bbl_dec == '0) begin
                        nxt.bytes_remaining = rem_after;
                        nxt.block_address   = addr_after;
                        if (rem_after == '0) begin
                           out.res[1] = '{sbh_pkg::RK_DONE, 8'd0};
                           out.cnt    = 3'd2;
                           nxt.phase  = sbh_pkg::PH_IDLE;
                        end else begin
                           out.res[1] = '{sbh_pkg::RK_SEND, cmd_cur};
                           out.res[2] = '{sbh_pkg::RK_SEND, ~cmd_cur};
                           out.cnt    = 3'd3;
                           nxt.phase  = sbh_pkg::PH_CMD_ACK;
                        end
                     end
                  end
                  default: begin
                     out.res[0] = '{sbh_pkg::RK_ORDER, 8'd0};
                     out.cnt    = 3'd1;
                  end
               endcase
            end
         end

         default: begin
            out.res[0] = '{sbh_pkg::RK_ORDER, 8'd0};
            out.cnt    = 3'd1;
         end
      endcase
   end

endmodule

// ===== tb/sv/sbh_host_checker.sv =====
// Checker for the serial bootloader host engine: watches both channels, predicts the
// results of every accepted request and compares them in order with the block's output.
// Depends on sbh_pkg, sbh_req_if and sbh_rsp_if.
module sbh_host_checker (
   input  logic        clock,
   input  logic        reset,
   sbh_req_if          req_ch,
   sbh_rsp_if          rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned results_owed
);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       last;
   } host_result_type;

   host_result_type owed_results[$];
   int unsigned     errors = 0;

   logic [3:0]  phase;
   logic [1:0]  cur_op;
   logic [31:0] blk_addr;
   logic [16:0] remaining;
   logic [8:0]  blk_left;
   logic [7:0]  csum;
   logic        retried;

   function automatic void push_result(logic [2:0] k, logic [7:0] d);
      host_result_type r;
      r.kind = k;
      r.data = d;
      r.last = 1'b0;
      owed_results.push_back(r);
   endfunction

   function automatic void send_command(logic [7:0] c);
      push_result(sbh_pkg::RK_SEND, c);
      push_result(sbh_pkg::RK_SEND, ~c);
   endfunction

   function automatic logic [8:0] block_len();
      return (remaining < 17'(sbh_pkg::BLOCK_SIZE)) ? remaining[8:0]
                                                     : 9'(sbh_pkg::BLOCK_SIZE);
   endfunction

   function automatic void finish_op();
      push_result(sbh_pkg::RK_DONE, 8'h00);
      phase = sbh_pkg::PH_IDLE;
   endfunction

   function automatic void fail_op(logic [7:0] b);
      push_result((b == sbh_pkg::NACK_BYTE) ? sbh_pkg::RK_NACK : sbh_pkg::RK_BAD, b);
      phase = sbh_pkg::PH_IDLE;
   endfunction

   function automatic void start_block();
      send_command((cur_op == sbh_pkg::OP_WRITE) ? sbh_pkg::CMD_WRITE : sbh_pkg::CMD_READ);
      phase = sbh_pkg::PH_CMD_ACK;
   endfunction

   function automatic void send_address();
      push_result(sbh_pkg::RK_SEND, blk_addr[31:24]);
      push_result(sbh_pkg::RK_SEND, blk_addr[23:16]);
      push_result(sbh_pkg::RK_SEND, blk_addr[15:8]);
      push_result(sbh_pkg::RK_SEND, blk_addr[7:0]);
      push_result(sbh_pkg::RK_SEND,
                  blk_addr[31:24] ^ blk_addr[23:16] ^ blk_addr[15:8] ^ blk_addr[7:0]);
   endfunction

   function automatic void advance_block();
      logic [8:0] blk;
      blk = block_len();
      remaining = remaining - 17'(blk);
      blk_addr = blk_addr + 32'(blk);
      if (remaining == 17'd0) finish_op();
      else start_block();
   endfunction

   function automatic void open_operation(logic [1:0] op, logic [31:0] addr, logic [16:0] len);
      cur_op = op;
      retried = 1'b0;
      csum = 8'h00;
      blk_left = 9'd0;
      case (op)
         sbh_pkg::OP_CONNECT: begin
            push_result(sbh_pkg::RK_SEND, sbh_pkg::SYNC_BYTE);
            phase = sbh_pkg::PH_CONN_ACK;
         end
         sbh_pkg::OP_ERASE: begin
            send_command(sbh_pkg::CMD_ERASE);
            phase = sbh_pkg::PH_ERASE_ACK1;
         end
         default: begin
            blk_addr = addr;
            remaining = (len > sbh_pkg::MAX_LENGTH) ? 17'(sbh_pkg::MAX_LENGTH) : len;
            if (remaining == 17'd0) finish_op();
            else start_block();
         end
      endcase
   endfunction

   function automatic void take_reply(logic [7:0] b);
      logic       ok;
      logic [8:0] blk;
      logic [8:0] blk_m1;
      ok = (b == sbh_pkg::ACK_BYTE);
      case (phase)
         sbh_pkg::PH_CONN_ACK: begin
            if (ok) finish_op();
            else if (!retried) begin
               retried = 1'b1;
               push_result(sbh_pkg::RK_SEND, sbh_pkg::SYNC_BYTE);
            end else fail_op(b);
         end
         sbh_pkg::PH_ERASE_ACK1: begin
            if (!ok) fail_op(b);
            else begin
               send_command(sbh_pkg::ERASE_ALL);
               phase = sbh_pkg::PH_ERASE_ACK2;
            end
         end
         sbh_pkg::PH_ERASE_ACK2: begin
            if (ok) finish_op();
            else fail_op(b);
         end
         sbh_pkg::PH_CMD_ACK: begin
            if (!ok) fail_op(b);
            else begin
               send_address();
               phase = sbh_pkg::PH_ADDR_ACK;
            end
         end
         sbh_pkg::PH_ADDR_ACK: begin
            if (!ok) fail_op(b);
            else begin
               blk = block_len();
               blk_m1 = blk - 9'd1;
               blk_left = blk;
               if (cur_op == sbh_pkg::OP_WRITE) begin
                  csum = blk_m1[7:0];
                  push_result(sbh_pkg::RK_SEND, blk_m1[7:0]);
                  push_result(sbh_pkg::RK_READY, 8'h00);
                  phase = sbh_pkg::PH_WR_DATA;
               end else begin
                  send_command(blk_m1[7:0]);
                  phase = sbh_pkg::PH_RD_CNT_ACK;
               end
            end
         end
         sbh_pkg::PH_WR_ACK: begin
            if (!ok) fail_op(b);
            else advance_block();
         end
         sbh_pkg::PH_RD_CNT_ACK: begin
            if (!ok) fail_op(b);
            else phase = sbh_pkg::PH_RD_DATA;
         end
         sbh_pkg::PH_RD_DATA: begin
            push_result(sbh_pkg::RK_READ, b);
            if (blk_left != 9'd0) blk_left = blk_left - 9'd1;
            if (blk_left == 9'd0) advance_block();
         end
         default: push_result(sbh_pkg::RK_ORDER, 8'h00);
      endcase
   endfunction

   function automatic void predict_host_step(logic [1:0] kind, logic [1:0] op,
                                             logic [31:0] addr, logic [16:0] len,
                                             logic [7:0] b);
      int start;
      start = owed_results.size();
      case (kind)
         sbh_pkg::IK_REQ: begin
            if (phase == sbh_pkg::PH_IDLE) open_operation(op, addr, len);
            else push_result(sbh_pkg::RK_ORDER, 8'h00);
         end
         sbh_pkg::IK_DATA: begin
            if (phase == sbh_pkg::PH_WR_DATA && blk_left != 9'd0) begin
               push_result(sbh_pkg::RK_SEND, b);
               csum = csum ^ b;
               blk_left = blk_left - 9'd1;
               if (blk_left == 9'd0) begin
                  push_result(sbh_pkg::RK_SEND, csum);
                  phase = sbh_pkg::PH_WR_ACK;
               end
            end else push_result(sbh_pkg::RK_ORDER, 8'h00);
         end
         sbh_pkg::IK_REPLY: take_reply(b);
         default: push_result(sbh_pkg::RK_ORDER, 8'h00);
      endcase
      if (owed_results.size() > start) owed_results[owed_results.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_result(logic [2:0] k, logic [7:0] d, logic l);
      host_result_type want;
      if (owed_results.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected result: kind %0d byte %02h last %0d", k, d, l);
      end else begin
         want = owed_results.pop_front();
         if (want.kind !== k || want.data !== d || want.last !== l) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected kind %0d byte %02h last %0d, ",
                         "got kind %0d byte %02h last %0d"},
                        want.kind, want.data, want.last, k, d, l);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase = sbh_pkg::PH_IDLE;
         cur_op = 2'd0;
         blk_addr = 32'd0;
         remaining = 17'd0;
         blk_left = 9'd0;
         csum = 8'h00;
         retried = 1'b0;
         owed_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_host_step(req_ch.kind, req_ch.operation, req_ch.address, req_ch.length,
                              req_ch.byte_in);
         if (rsp_ch.valid && rsp_ch.ready)
            compare_result(rsp_ch.result_kind, rsp_ch.byte_out, rsp_ch.last);
      end
      mismatch_count <= errors;
      results_owed <= owed_results.size();
   end

endmodule

// ===== tb/sv/tb_serial_bootloader_host_engine.sv =====
// Top of the serial bootloader host engine testbench: clock, reset, request stimulus,
// result-side back-pressure and the verdict.
// Depends on sbh_pkg, sbh_req_if, sbh_rsp_if, serial_bootloader_host_engine, sbh_host_checker.
module tb_serial_bootloader_host_engine;

   localparam logic [1:0] IK_UNUSED = 2'd3;
   localparam int RUN_LIMIT   = 200000;
   localparam int ITEM_GOAL   = 410;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        calm;
   logic        hold_off;
   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned cycle_count = 0;
   int          item_count;
   int          fail_at;

   sbh_req_if req_ch();
   sbh_rsp_if rsp_ch();

   serial_bootloader_host_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sbh_host_checker host_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off, none while calm
   initial begin : result_drain
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
      end
   end

   task automatic offer(logic [1:0] k, logic [1:0] op, logic [31:0] a, logic [16:0] len,
                        logic [7:0] b);
      item_count++;
      if (!calm && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= k;
      req_ch.operation <= op;
      req_ch.address   <= a;
      req_ch.length    <= len;
      req_ch.byte_in   <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic request(logic [1:0] op, logic [31:0] a, logic [16:0] len);
      offer(sbh_pkg::IK_REQ, op, a, len, 8'($urandom));
   endtask

   task automatic data(logic [7:0] b);
      offer(sbh_pkg::IK_DATA, 2'($urandom), $urandom, 17'($urandom), b);
   endtask

   task automatic reply(logic [7:0] b);
      offer(sbh_pkg::IK_REPLY, 2'($urandom), $urandom, 17'($urandom), b);
   endtask

   // requests the block must flag and ignore in its current phase
   task automatic noise(bit busy, bit data_phase);
      logic [1:0] k;
      int         r;
      k = IK_UNUSED;
      r = $urandom_range(2);
      if (r == 0) k = busy ? sbh_pkg::IK_REQ : sbh_pkg::IK_DATA;
      else if (r == 1) k = (!busy || data_phase) ? sbh_pkg::IK_REPLY : sbh_pkg::IK_DATA;
      offer(k, 2'($urandom), $urandom, 17'($urandom), 8'($urandom));
   endtask

   task automatic maybe_noise(bit data_phase);
      if ($urandom_range(19) == 0) noise(1'b1, data_phase);
   endtask

   function automatic logic [7:0] non_ack_byte();
      logic [7:0] b;
      b = $urandom_range(1) ? sbh_pkg::NACK_BYTE : 8'($urandom);
      return (b == sbh_pkg::ACK_BYTE) ? ~b : b;
   endfunction

   task automatic ack_reply(output bit good);
      logic [7:0] b;
      b = (fail_at == 0) ? non_ack_byte() : sbh_pkg::ACK_BYTE;
      if (fail_at >= 0) fail_at--;
      maybe_noise(1'b0);
      reply(b);
      good = (b == sbh_pkg::ACK_BYTE);
   endtask

   task automatic run_connect();
      logic [7:0] b;
      request(sbh_pkg::OP_CONNECT, $urandom, 17'($urandom));
      b = ($urandom_range(2) != 0) ? sbh_pkg::ACK_BYTE : non_ack_byte();
      maybe_noise(1'b0);
      reply(b);
      if (b != sbh_pkg::ACK_BYTE) begin
         b = $urandom_range(1) ? sbh_pkg::ACK_BYTE : non_ack_byte();
         maybe_noise(1'b0);
         reply(b);
      end
   endtask

   task automatic run_erase();
      bit good;
      request(sbh_pkg::OP_ERASE, $urandom, 17'($urandom));
      ack_reply(good);
      if (good) ack_reply(good);
   endtask

   task automatic run_transfer(logic [1:0] op, logic [31:0] a, logic [16:0] len);
      int left;
      int blk;
      bit good;
      request(op, a, len);
      left = (len > sbh_pkg::MAX_LENGTH) ? sbh_pkg::MAX_LENGTH : int'(len);
      while (left > 0) begin
         ack_reply(good);
         if (!good) return;
         ack_reply(good);
         if (!good) return;
         blk = (left < sbh_pkg::BLOCK_SIZE) ? left : sbh_pkg::BLOCK_SIZE;
         if (op == sbh_pkg::OP_WRITE) begin
            for (int i = 0; i < blk; i++) begin
               maybe_noise(1'b1);
               data(8'($urandom));
            end
            ack_reply(good);
            if (!good) return;
         end else begin
            ack_reply(good);
            if (!good) return;
            for (int i = 0; i < blk; i++) begin
               maybe_noise(1'b0);
               reply(8'($urandom));
            end
         end
         left -= blk;
      end
   endtask

   task automatic run_random_sequence();
      logic [1:0]  op;
      logic [16:0] len;
      int          r;
      op = 2'($urandom);
      r = $urandom_range(99);
      fail_at = ($urandom_range(99) < 85) ? -1 : int'($urandom_range(4));
      if (r < 5) len = 17'd0;
      else if (r < 10) begin
         len = 17'($urandom_range(131071, 65536));
         fail_at = $urandom_range(1);
      end else if (r < 22) len = 17'($urandom_range(64, 13));
      else len = 17'($urandom_range(12, 1));
      case (op)
         sbh_pkg::OP_CONNECT: run_connect();
         sbh_pkg::OP_ERASE:   run_erase();
         default:             run_transfer(op, $urandom, len);
      endcase
      if ($urandom_range(7) == 0) noise(1'b0, 1'b0);
   endtask

   initial begin : stimulus
      int seq;
      reset            <= 1'b1;
      calm             <= 1'b0;
      hold_off         <= 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= sbh_pkg::IK_REQ;
      req_ch.operation <= sbh_pkg::OP_CONNECT;
      req_ch.address   <= '0;
      req_ch.length    <= '0;
      req_ch.byte_in   <= '0;
      fail_at = -1;
      item_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // unused kind, data and reply while idle
      offer(IK_UNUSED, sbh_pkg::OP_READ, 32'hFFFF_FFFF, 17'h1FFFF, 8'hFF);
      data(8'h00);
      reply(sbh_pkg::ACK_BYTE);
      request(sbh_pkg::OP_CONNECT, 32'd0, 17'd0);
      reply(sbh_pkg::ACK_BYTE);
      // connect: nack, retry, then a bad reply
      request(sbh_pkg::OP_CONNECT, 32'd0, 17'd0);
      reply(sbh_pkg::NACK_BYTE);
      reply(8'hFF);
      // erase with a request arriving while busy
      request(sbh_pkg::OP_ERASE, 32'd0, 17'd0);
      request(sbh_pkg::OP_READ, 32'd0, 17'd1);
      reply(sbh_pkg::ACK_BYTE);
      reply(sbh_pkg::ACK_BYTE);
      request(sbh_pkg::OP_WRITE, 32'd0, 17'd0);
      // oversized length, aborted at the address ack
      request(sbh_pkg::OP_WRITE, 32'hFFFF_FFFF, 17'h1FFFF);
      reply(sbh_pkg::ACK_BYTE);
      reply(sbh_pkg::NACK_BYTE);
      request(sbh_pkg::OP_WRITE, 32'd0, 17'd1);
      reply(sbh_pkg::ACK_BYTE);
      reply(sbh_pkg::ACK_BYTE);
      data(8'hFF);
      reply(sbh_pkg::ACK_BYTE);
      request(sbh_pkg::OP_READ, 32'h8000_0000, 17'd1);
      reply(sbh_pkg::ACK_BYTE);
      reply(sbh_pkg::ACK_BYTE);
      reply(sbh_pkg::ACK_BYTE);
      reply(sbh_pkg::NACK_BYTE);

      seq = 0;
      while (item_count < ITEM_GOAL) begin
         if (seq == 0) begin
            // sender waits until every result has drained
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (results_owed != 0) @(posedge clock);
         end
         if (seq == 1) begin
            // long result hold-off at the start of a multi-block transfer across the top of the
            // address space with no idling on either side
            hold_off <= 1'b1;
            calm     <= 1'b1;
            fail_at = -1;
            run_transfer($urandom_range(1) ? sbh_pkg::OP_WRITE : sbh_pkg::OP_READ,
                         32'hFFFF_FF00 + $urandom_range(255), 17'($urandom_range(264, 257)));
            calm <= 1'b0;
         end
         run_random_sequence();
         seq++;
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
